### rtl/sli_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the sorted list insert/pop core.
package sli_pkg;

  localparam int unsigned DEPTH  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_INSERT   = 3'd0,
    KIND_PUSH     = 3'd1,
    KIND_POP      = 3'd2,
    KIND_LIST_FWD = 3'd3,
    KIND_LIST_REV = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_FROM_PREV = 2'd2,
    CELL_FROM_NEXT = 2'd3
  } cell_op_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_EXEC = 2'd1,
    FSM_LIST = 2'd2
  } state_e;

  typedef struct packed {
    cell_op_e          op;
    logic [DATA_W-1:0] load_val;
  } cell_ctl_t;

  function automatic logic [DEPTH-1:0] below_mask(input int unsigned idx);
    logic [DEPTH-1:0] m;
    m = '0;
    for (int unsigned j = 0; j < DEPTH; j++) begin
      m[j] = (j < idx);
    end
    return m;
  endfunction

endpackage

### rtl/sli_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list chain with its neighbor muxing and compare.
module sli_cell import sli_pkg::*; (
  input  logic              clk_i,
  input  cell_ctl_t         ctl_i,
  input  logic [DATA_W-1:0] prev_i,
  input  logic [DATA_W-1:0] next_i,
  input  logic [DATA_W-1:0] cmp_val_i,
  output logic [DATA_W-1:0] value_o,
  output logic              gt_o
);

  logic [DATA_W-1:0] value_q;
  logic [DATA_W-1:0] value_d;

  always_comb begin
    unique case (ctl_i.op)
      CELL_HOLD:      value_d = value_q;
      CELL_LOAD:      value_d = ctl_i.load_val;
      CELL_FROM_PREV: value_d = prev_i;
      CELL_FROM_NEXT: value_d = next_i;
      default:        value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign gt_o    = $signed(value_q) > $signed(cmp_val_i);

endmodule

### rtl/sorted_list_insert_pop_core.sv
`timescale 1ns / 1ps
// Sorted list core: a chain of value cells that keeps a bounded list of signed words.
// Each word in is accepted while every cell compares its value with the incoming one;
// then, once the output is free, the whole chain shifts at once to carry out an ordered
// insert, push-front or pop-front, or nothing for an unknown kind. A listing of the stored
// words rotates the chain by one cell per cycle and hands out one word per cycle while
// the output is not stalled, forward from the head or reverse from the tail, and ends with
// the list as it was. A stalled output holds the chain. Input is taken only while the core
// is idle, and the result register lets a new word in while the last result waits.
module sorted_list_insert_pop_core import sli_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               kind_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic [2:0]        kind_q, kind_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic [DEPTH-1:0]  gt_q, gt_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  status_e           out_status_q, out_status_d;
  logic              out_last_q, out_last_d;

  logic [DATA_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]  cell_gt;
  cell_op_e          cell_op [DEPTH];
  cell_ctl_t         cell_ctl [DEPTH];
  logic [DATA_W-1:0] load_val;

  logic [CNT_W-1:0]  count_m1;
  logic [DEPTH-1:0]  occ;
  logic [DEPTH-1:0]  is_top;
  logic [DEPTH-1:0]  gtx;
  logic [DEPTH-1:0]  shift_up;
  logic [DATA_W-1:0] head;
  logic [DATA_W-1:0] tail;
  logic              out_free;
  logic              list_fwd;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] prev_val;
    logic [DATA_W-1:0] next_val;
    if (g == 0) begin : g_first
      assign prev_val = '0;
    end else begin : g_inner_prev
      assign prev_val = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_val = '0;
    end else begin : g_inner_next
      assign next_val = cell_val[g+1];
    end
    sli_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (cell_ctl[g]),
      .prev_i    (prev_val),
      .next_i    (next_val),
      .cmp_val_i (value_i),
      .value_o   (cell_val[g]),
      .gt_o      (cell_gt[g])
    );
  end

  assign count_m1 = count_q - CNT_W'(1);
  assign head     = cell_val[0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign list_fwd = (kind_q == KIND_LIST_FWD);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i]    = CNT_W'(i) < count_q;
      is_top[i] = CNT_W'(i) == count_m1;
      gtx[i]    = (kind_q == KIND_PUSH) || (gt_q[i] && occ[i]) || (CNT_W'(i) == count_q);
    end
    for (int i = 0; i < DEPTH; i++) begin
      shift_up[i] = |(gtx & below_mask(i));
    end
  end

  always_comb begin
    tail = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail = tail | (cell_val[i] & {DATA_W{is_top[i]}});
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    left_d       = left_q;
    kind_d       = kind_q;
    value_d      = value_q;
    gt_d         = gt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    load_val     = value_q;
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
    end

    unique case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          value_d = value_i;
          gt_d    = cell_gt;
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_data_d   = '0;
          out_status_d = ST_OK;
          out_last_d   = 1'b1;
          state_d      = FSM_IDLE;
          unique case (kind_q)
            KIND_INSERT, KIND_PUSH: begin
              if (count_q == CNT_W'(DEPTH)) begin
                out_status_d = ST_FULL;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (gtx[i] && !shift_up[i]) begin
                    cell_op[i] = CELL_LOAD;
                  end else if (shift_up[i] && (CNT_W'(i) <= count_q)) begin
                    cell_op[i] = CELL_FROM_PREV;
                  end
                end
                count_d = count_q + CNT_W'(1);
              end
            end
            KIND_POP: begin
              if (count_q == '0) begin
                out_status_d = ST_EMPTY;
              end else begin
                out_data_d = head;
                for (int i = 0; i < DEPTH - 1; i++) begin
                  cell_op[i] = CELL_FROM_NEXT;
                end
                count_d = count_m1;
              end
            end
            KIND_LIST_FWD, KIND_LIST_REV: begin
              if (count_q == '0) begin
                out_status_d = ST_EMPTY;
              end else begin
                out_data_d = list_fwd ? head : tail;
                load_val   = list_fwd ? head : tail;
                for (int i = 0; i < DEPTH; i++) begin
                  if (list_fwd) begin
                    if (is_top[i]) begin
                      cell_op[i] = CELL_LOAD;
                    end else if (occ[i]) begin
                      cell_op[i] = CELL_FROM_NEXT;
                    end
                  end else begin
                    if (i == 0) begin
                      cell_op[i] = CELL_LOAD;
                    end else if (occ[i]) begin
                      cell_op[i] = CELL_FROM_PREV;
                    end
                  end
                end
                left_d = count_m1;
                if (count_q != CNT_W'(1)) begin
                  out_last_d = 1'b0;
                  state_d    = FSM_LIST;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      FSM_LIST: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_data_d   = list_fwd ? head : tail;
          out_status_d = ST_OK;
          out_last_d   = (left_q == CNT_W'(1));
          load_val     = list_fwd ? head : tail;
          for (int i = 0; i < DEPTH; i++) begin
            if (list_fwd) begin
              if (is_top[i]) begin
                cell_op[i] = CELL_LOAD;
              end else if (occ[i]) begin
                cell_op[i] = CELL_FROM_NEXT;
              end
            end else begin
              if (i == 0) begin
                cell_op[i] = CELL_LOAD;
              end else if (occ[i]) begin
                cell_op[i] = CELL_FROM_PREV;
              end
            end
          end
          left_d = left_q - CNT_W'(1);
          if (left_q == CNT_W'(1)) begin
            state_d = FSM_IDLE;
          end
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i].op       = cell_op[i];
      cell_ctl[i].load_val = load_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    value_q      <= value_d;
    gt_q         <= gt_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign in_stall_o  = (state_q != FSM_IDLE);
  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("List count exceeds capacity.");

  a_list_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_LIST |-> (left_q != '0) && (left_q < count_q))
    else $error("Listing word counter out of range.");

  a_list_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_LIST |=> count_q == $past(count_q))
    else $error("Listing changed the list length.");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_EXEC) && out_free && (kind_q == KIND_POP) && (count_q != '0)
    |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("Pop did not shorten the list.");

  a_list_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_LIST) && out_free && (left_q == CNT_W'(1))
    |=> (state_q == FSM_IDLE) && out_valid_o && last_o)
    else $error("Listing did not end with a last word.");

endmodule

### test/tb_sorted_list_insert_pop_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_list_insert_pop_core: directed table, then random runs.
module tb_sorted_list_insert_pop_core;
  import sli_pkg::*;

  localparam logic [2:0] KIND_SPARE_5 = 3'd5;
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam int RANDOM_WORDS = 270;
  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT  = 1000;
  localparam int ROW_COUNT    = 24;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    status_e                  status;
    logic                     last;
  } word_t;

  typedef struct {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    logic signed [DATA_W-1:0] data;
    status_e                  status;
  } row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [2:0]               kind_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] data_out_o;
  logic [1:0]               status_o;
  logic                     last_o;

  logic signed [DATA_W-1:0] stored_values [$];
  word_t                    pending_words [$];
  row_t                     directed_rows [ROW_COUNT];

  bit burst;
  bit hold_request;
  int mismatches;
  int words_sent;
  int words_checked;
  int full_refusals;
  int peak_fill;
  int quiet_cycles;

  sorted_list_insert_pop_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_out_o  (data_out_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void apply_list_op(input logic [2:0] kind,
                                        input logic signed [DATA_W-1:0] value);
    int pos;
    int n;
    int idx;
    n = stored_values.size();
    case (kind)
      KIND_INSERT, KIND_PUSH: begin
        if (n >= DEPTH) begin
          pending_words.push_back('{32'sd0, ST_FULL, 1'b1});
        end else begin
          pos = 0;
          if (kind == KIND_INSERT) begin
            while (pos < n && stored_values[pos] <= value) pos++;
          end
          stored_values.insert(pos, value);
          pending_words.push_back('{32'sd0, ST_OK, 1'b1});
        end
      end
      KIND_POP: begin
        if (n == 0) begin
          pending_words.push_back('{32'sd0, ST_EMPTY, 1'b1});
        end else begin
          pending_words.push_back('{stored_values.pop_front(), ST_OK, 1'b1});
        end
      end
      KIND_LIST_FWD, KIND_LIST_REV: begin
        if (n == 0) begin
          pending_words.push_back('{32'sd0, ST_EMPTY, 1'b1});
        end else begin
          for (int i = 0; i < n; i++) begin
            idx = (kind == KIND_LIST_FWD) ? i : n - 1 - i;
            pending_words.push_back('{stored_values[idx], ST_OK, i == n - 1});
          end
        end
      end
      default: begin
        pending_words.push_back('{32'sd0, ST_OK, 1'b1});
      end
    endcase
    if (stored_values.size() > peak_fill) peak_fill = stored_values.size();
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1: return int'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] rand_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 38) return KIND_INSERT;
    if (r < 48) return KIND_PUSH;
    if (r < 72) return KIND_POP;
    if (r < 82) return KIND_LIST_FWD;
    if (r < 92) return KIND_LIST_REV;
    return 3'($urandom_range(KIND_SPARE_5, KIND_SPARE_7));
  endfunction

  task automatic send_word(input logic [2:0] kind, input logic signed [DATA_W-1:0] value);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    apply_list_op(kind, value);
    words_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  task automatic fill_and_empty();
    while (stored_values.size() < DEPTH) begin
      send_word(($urandom_range(0, 4) == 0) ? KIND_PUSH : KIND_INSERT, rand_value());
    end
    send_word(KIND_INSERT, rand_value());
    send_word(KIND_PUSH, rand_value());
    send_word(KIND_LIST_FWD, rand_value());
    send_word(KIND_LIST_REV, rand_value());
    while (stored_values.size() != 0) send_word(KIND_POP, rand_value());
    send_word(KIND_POP, rand_value());
  endtask

  task automatic mixed_run(input int len, input bit with_hold);
    if (with_hold) hold_request = 1'b1;
    repeat (len) send_word(rand_kind(), rand_value());
  endtask

  initial begin : receiver
    int stall_cycles;
    word_t want;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall_cycles = burst ? 0 : $urandom_range(0, 4);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_cycles += HOLD_CYCLES;
      end
      if (stall_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_words.size() == 0) begin
        $error("unexpected result word: data_out %0d status %0d last %0d",
               data_out_o, status_o, last_o);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (want.status == ST_FULL) full_refusals++;
        if (data_out_o !== want.data) begin
          $error("data_out expected %0d actual %0d", want.data, data_out_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status expected %0d actual %0d", want.status, status_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last expected %0d actual %0d", want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sorted_list_insert_pop_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int episode;
    directed_rows = '{
      '{KIND_POP,      32'sd0,   1'b1, 32'sd0,  ST_EMPTY},
      '{KIND_LIST_FWD, 32'sd0,   1'b1, 32'sd0,  ST_EMPTY},
      '{KIND_LIST_REV, 32'sd0,   1'b1, 32'sd0,  ST_EMPTY},
      '{KIND_INSERT,   32'sd42,  1'b1, 32'sd0,  ST_OK},
      '{KIND_POP,      32'sd0,   1'b1, 32'sd42, ST_OK},
      '{KIND_POP,      32'sd0,   1'b1, 32'sd0,  ST_EMPTY},
      '{KIND_INSERT,   VAL_MAX,  1'b1, 32'sd0,  ST_OK},
      '{KIND_INSERT,   VAL_MIN,  1'b1, 32'sd0,  ST_OK},
      '{KIND_INSERT,   32'sd0,   1'b0, 32'sd0,  ST_OK},
      '{KIND_INSERT,   -32'sd1,  1'b0, 32'sd0,  ST_OK},
      '{KIND_INSERT,   32'sd0,   1'b0, 32'sd0,  ST_OK},
      '{KIND_PUSH,     32'sd7,   1'b1, 32'sd0,  ST_OK},
      '{KIND_PUSH,     VAL_MAX,  1'b0, 32'sd0,  ST_OK},
      '{KIND_LIST_FWD, 32'sd0,   1'b0, 32'sd0,  ST_OK},
      '{KIND_LIST_REV, 32'sd0,   1'b0, 32'sd0,  ST_OK},
      '{KIND_SPARE_5,  VAL_MIN,  1'b1, 32'sd0,  ST_OK},
      '{KIND_SPARE_6,  -32'sd1,  1'b1, 32'sd0,  ST_OK},
      '{KIND_SPARE_7,  VAL_MAX,  1'b1, 32'sd0,  ST_OK},
      '{KIND_POP,      32'sd0,   1'b0, 32'sd0,  ST_OK},
      '{KIND_INSERT,   32'sd1,   1'b0, 32'sd0,  ST_OK},
      '{KIND_INSERT,   VAL_MIN,  1'b0, 32'sd0,  ST_OK},
      '{KIND_LIST_FWD, 32'sd0,   1'b0, 32'sd0,  ST_OK},
      '{KIND_POP,      32'sd0,   1'b0, 32'sd0,  ST_OK},
      '{KIND_LIST_REV, 32'sd0,   1'b0, 32'sd0,  ST_OK}
    };
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    kind_i       <= KIND_INSERT;
    value_i      <= '0;
    burst        = 1'b0;
    hold_request = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].kind, directed_rows[i].value);
      // Rows with a written-out answer replace the computed one.
      if (directed_rows[i].typed) begin
        void'(pending_words.pop_back());
        pending_words.push_back('{directed_rows[i].data, directed_rows[i].status, 1'b1});
      end
    end
    drain();

    episode = 0;
    while (words_sent - ROW_COUNT < RANDOM_WORDS) begin
      burst = ($urandom_range(0, 3) == 0);
      if (episode == 0 || episode == 6) begin
        fill_and_empty();
      end else begin
        mixed_run($urandom_range(10, 35), episode == 2);
      end
      if (episode == 3 || $urandom_range(0, 2) == 0) drain();
      episode++;
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d words (%0d from the table) and checked %0d result words.",
             words_sent, ROW_COUNT, words_checked);
    $display("The list peaked at %0d of %0d entries; %0d inserts were refused as full.",
             peak_fill, DEPTH, full_refusals);
    if (mismatches == 0) begin
      $display("sorted_list_insert_pop_core regression: pass");
    end else begin
      $display("sorted_list_insert_pop_core regression: fail");
    end
    $finish;
  end

endmodule
